// ===== sv/flep_pkg.sv =====
// Package for the fixed-point log2/exp2/power unit: payload types, codes,
// polynomial coefficients and shared arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package flep_pkg;

    typedef enum logic [1:0] {
        ACT_LOG2 = 2'd0,
        ACT_EXP2 = 2'd1,
        ACT_POW  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DOMAIN = 2'd1,
        ST_OVF    = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [1:0]         status;
    } out_item_t;

    localparam logic [31:0] LG0 = 32'd1901359519;
    localparam logic [31:0] LG1 = 32'd3098003232;
    localparam logic [31:0] LG2 = 32'd2061857896;
    localparam logic [31:0] LG3 = 32'd1517819172;
    localparam logic [31:0] LG4 = 32'd1099553409;
    localparam logic [31:0] LG5 = 32'd667231027;
    localparam logic [31:0] LG6 = 32'd273193960;
    localparam logic [31:0] LG7 = 32'd52912485;

    localparam logic [31:0] EX0 = 32'd2977044474;
    localparam logic [31:0] EX1 = 32'd1031764910;
    localparam logic [31:0] EX2 = 32'd238389642;
    localparam logic [31:0] EX3 = 32'd41301581;
    localparam logic [31:0] EX4 = 32'd5749599;
    localparam logic [31:0] EX5 = 32'd628344;
    localparam logic [31:0] EX6 = 32'd88747;

    localparam logic [31:0] LOG_ZERO = 32'h8000_0000;
    localparam logic [31:0] EXP_SAT  = 32'h7FFF_FFFF;

    function automatic logic [31:0] mulhi(input logic [31:0] p, input logic [31:0] q);
        logic [63:0] prod;
        prod = {32'd0, p} * {32'd0, q};
        return prod[63:32];
    endfunction

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/flep_log2.sv =====
// Pipelined log2 of a 32-bit unsigned operand, s15.16 result, 5 register stages.
// Depends on flep_pkg. Carries a sideband word alongside the data.
`timescale 1ns / 1ps
module flep_log2 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [31:0]  operand,
    input  logic [65:0]  side_in,
    output logic         out_valid,
    output logic [31:0]  value,
    output logic         domain,
    output logic [65:0]  side_out
);
    import flep_pkg::*;

    localparam int Depth = 5;

    logic [Depth-1:0] vld_reg;
    logic [65:0]      side_reg [Depth];
    logic             dom_reg  [Depth];
    logic [5:0]       lz_reg   [Depth];

    // stage 0: normalize
    logic [31:0] f0_reg;
    // stage 1: f2 and first-level products
    logic [31:0] f1_reg, f2_1_reg, m1_reg, m3_reg, m5_reg, m7_reg;
    // stage 2: f4 and inner terms
    logic [31:0] f2_reg, f2_2_reg, f4_2_reg, t0_2_reg, u1_2_reg, u2_2_reg, u3_2_reg;
    // stage 3: weighted terms
    logic [31:0] f3_reg, t0_3_reg, t1_3_reg, t2_3_reg;
    // stage 4: final product and rounding
    logic [31:0] val4_reg;

    logic [63:0] shifted;
    logic [31:0] acc;
    logic [31:0] rnd;

    always_comb begin
        shifted = {32'd0, operand} << (lzc32(operand) + 6'd1);
        acc = f3_reg + mulhi(f3_reg, t0_3_reg + t1_3_reg + t2_3_reg);
        rnd = ((32'd15 - {26'd0, lz_reg[3]}) << 16) + (((acc >> 15) + 32'd1) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else if (en) begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            side_reg[0] <= side_in;
            dom_reg[0]  <= (operand == 32'd0);
            lz_reg[0]   <= lzc32(operand);
            f0_reg      <= shifted[31:0];
            for (int i = 1; i < Depth; i++) begin
                side_reg[i] <= side_reg[i-1];
                dom_reg[i]  <= dom_reg[i-1];
                lz_reg[i]   <= lz_reg[i-1];
            end

            f1_reg   <= f0_reg;
            f2_1_reg <= mulhi(f0_reg, f0_reg);
            m1_reg   <= mulhi(LG1, f0_reg);
            m3_reg   <= mulhi(LG3, f0_reg);
            m5_reg   <= mulhi(LG5, f0_reg);
            m7_reg   <= mulhi(LG7, f0_reg);

            f2_reg   <= f1_reg;
            f2_2_reg <= f2_1_reg;
            f4_2_reg <= mulhi(f2_1_reg, f2_1_reg);
            t0_2_reg <= LG0 - m1_reg;
            u1_2_reg <= LG2 - m3_reg;
            u2_2_reg <= LG4 - m5_reg;
            u3_2_reg <= mulhi(LG6 - m7_reg, f2_1_reg);

            f3_reg   <= f2_reg;
            t0_3_reg <= t0_2_reg;
            t1_3_reg <= mulhi(u1_2_reg, f2_2_reg);
            t2_3_reg <= mulhi(u2_2_reg + u3_2_reg, f4_2_reg);

            val4_reg <= dom_reg[3] ? LOG_ZERO : rnd;
        end
    end

    assign out_valid = vld_reg[Depth-1];
    assign value     = val4_reg;
    assign domain    = dom_reg[Depth-1];
    assign side_out  = side_reg[Depth-1];

endmodule

// ===== sv/flep_exp2.sv =====
// Pipelined exp2 of an s15.16 operand with saturation, 5 register stages.
// Depends on flep_pkg. Carries a sideband word alongside the data.
`timescale 1ns / 1ps
module flep_exp2 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] operand,
    input  logic [3:0]  side_in,
    output logic        out_valid,
    output logic [31:0] value,
    output logic        ovf,
    output logic [3:0]  side_out
);
    import flep_pkg::*;

    localparam int Depth = 5;

    logic [Depth-1:0] vld_reg;
    logic [3:0]       side_reg [Depth];
    logic             ovf_reg  [Depth];
    logic             unf_reg  [Depth];
    logic signed [16:0] ip_reg [Depth];

    logic [31:0] f0_reg;
    logic [31:0] f1_reg, f2_1_reg, m1_reg, m3_reg, m5_reg;
    logic [31:0] f2_reg, f2_2_reg, f4_2_reg, t0_2_reg, u1_2_reg, u2_2_reg;
    logic [31:0] f3_reg, t0_3_reg, t1_3_reg, t2_3_reg;
    logic [31:0] val4_reg;

    logic signed [16:0] ip_in;
    logic [31:0]        acc;
    logic [4:0]         sh_a;
    logic [4:0]         sh_b;
    logic [31:0]        rnd;

    always_comb begin
        ip_in = {operand[31], operand[31:16]};
        acc   = mulhi(f3_reg, t0_3_reg + t1_3_reg + t2_3_reg);
        // ip in [-16,14] here: 15-ip in [1,31], 14-ip in [0,30]
        sh_a  = 5'(17'sd15 - ip_reg[3]);
        sh_b  = 5'(17'sd14 - ip_reg[3]);
        rnd   = ((acc >> sh_a) + (LOG_ZERO >> sh_b) + 32'd1) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else if (en) begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            side_reg[0] <= side_in;
            ip_reg[0]   <= ip_in;
            ovf_reg[0]  <= (ip_in >= 17'sd15);
            unf_reg[0]  <= (ip_in < -17'sd16);
            f0_reg      <= {operand[15:0], 16'd0};
            for (int i = 1; i < Depth; i++) begin
                side_reg[i] <= side_reg[i-1];
                ip_reg[i]   <= ip_reg[i-1];
                ovf_reg[i]  <= ovf_reg[i-1];
                unf_reg[i]  <= unf_reg[i-1];
            end

            f1_reg   <= f0_reg;
            f2_1_reg <= mulhi(f0_reg, f0_reg);
            m1_reg   <= mulhi(EX1, f0_reg);
            m3_reg   <= mulhi(EX3, f0_reg);
            m5_reg   <= mulhi(EX5, f0_reg);

            f2_reg   <= f1_reg;
            f2_2_reg <= f2_1_reg;
            f4_2_reg <= mulhi(f2_1_reg, f2_1_reg);
            t0_2_reg <= EX0 + m1_reg;
            u1_2_reg <= EX2 + m3_reg;
            u2_2_reg <= EX4 + m5_reg + mulhi(EX6, f2_1_reg);

            f3_reg   <= f2_reg;
            t0_3_reg <= t0_2_reg;
            t1_3_reg <= mulhi(u1_2_reg, f2_2_reg);
            t2_3_reg <= mulhi(u2_2_reg, f4_2_reg);

            if (ovf_reg[3]) begin
                val4_reg <= EXP_SAT;
            end
            else if (unf_reg[3]) begin
                val4_reg <= 32'd0;
            end
            else begin
                val4_reg <= rnd;
            end
        end
    end

    assign out_valid = vld_reg[Depth-1];
    assign value     = val4_reg;
    assign ovf       = ovf_reg[Depth-1];
    assign side_out  = side_reg[Depth-1];

endmodule

// ===== sv/fixed_log2_exp2_pow_unit.sv =====
// Top level of the s15.16 log2/exp2/power unit: log2 pipe, round multiply
// stages, exp2 pipe and result queue. Depends on flep_pkg, flep_log2, flep_exp2.
`timescale 1ns / 1ps
// Accepts one operation per cycle while in_stall is low; each operation passes through
// 5 log2 stages (the first loaded at the transfer edge), 3 round-multiply
// stages (two 32x16 partial products, then sum and round, then exp2 operand select),
// 5 exp2 stages and the result queue. Every operation runs through the whole chain;
// log2 and exp2 select what they use. The pipeline never holds; a credit count caps
// the items accepted but not yet taken at the 16-entry queue depth, so the input
// stall is a registered signal and output stalls reach the input only once 16 items
// are outstanding.
module fixed_log2_exp2_pow_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  flep_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output flep_pkg::out_item_t out_data
);
    import flep_pkg::*;

    // result queue depth; also the cap on outstanding items
    localparam int QDepth = 16;
    localparam int CntW = $clog2(QDepth + 1);

    logic            en;
    logic [CntW-1:0] cnt_reg, cnt_next;

    // log2 stage
    logic        lg_valid;
    logic [31:0] lg_value;
    logic        lg_dom;
    logic [65:0] lg_side;

    // round multiply stages
    logic        rm_vld_reg [3];
    logic [1:0]  rm_act_reg [3];
    logic [31:0] rm_a_reg   [3];
    logic        rm_dom_reg [3];
    logic [31:0] rm_lg_reg  [2];
    logic signed [63:0] rm_plo_reg, rm_phi_reg;
    logic [31:0] rm_prod_reg;
    logic [63:0] rm_sum;

    // exp2 stage
    logic [31:0] ex_operand;
    logic        ex_valid;
    logic [31:0] ex_value;
    logic        ex_ovf;
    logic [3:0]  ex_side;
    logic [1:0]  ex_act;
    logic        ex_dom;

    out_item_t   res;
    // output FIFO
    out_item_t       q_reg [QDepth];
    logic [3:0]      wp_reg, rp_reg;
    logic [CntW-1:0] qn_reg;
    logic            push, pop;

    assign en = 1'b1;

    flep_log2 u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid && !in_stall),
        .operand  (in_data.operand_a),
        .side_in  ({in_data.action, in_data.operand_a, in_data.operand_b}),
        .out_valid(lg_valid),
        .value    (lg_value),
        .domain   (lg_dom),
        .side_out (lg_side)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                rm_vld_reg[i] <= 1'b0;
            end
        end
        else begin
            rm_vld_reg[0] <= lg_valid;
            rm_vld_reg[1] <= rm_vld_reg[0];
            rm_vld_reg[2] <= rm_vld_reg[1];
        end
    end

    assign rm_sum = 64'(rm_plo_reg + (rm_phi_reg <<< 16)) + 64'h8000;

    always_ff @(posedge clk) begin
        rm_act_reg[0] <= lg_side[65:64];
        rm_a_reg[0]   <= lg_side[63:32];
        rm_dom_reg[0] <= lg_dom;
        rm_lg_reg[0]  <= lg_value;
        // b * lg split as b * lg[15:0] + (b * lg[31:16]) << 16
        rm_plo_reg    <= 64'($signed(lg_side[31:0]) * $signed({1'b0, lg_value[15:0]}));
        rm_phi_reg    <= 64'($signed(lg_side[31:0]) * $signed(lg_value[31:16]));

        rm_act_reg[1] <= rm_act_reg[0];
        rm_a_reg[1]   <= rm_a_reg[0];
        rm_dom_reg[1] <= rm_dom_reg[0];
        rm_lg_reg[1]  <= rm_lg_reg[0];
        rm_prod_reg   <= rm_sum[47:16];

        rm_act_reg[2] <= rm_act_reg[1];
        rm_dom_reg[2] <= rm_dom_reg[1];
        unique case (action_t'(rm_act_reg[1]))
            ACT_EXP2: rm_a_reg[2] <= rm_a_reg[1];
            ACT_POW:  rm_a_reg[2] <= rm_prod_reg;
            ACT_LOG2: rm_a_reg[2] <= rm_lg_reg[1];
            default:  rm_a_reg[2] <= rm_lg_reg[1];
        endcase
    end

    assign ex_operand = rm_a_reg[2];

    flep_exp2 u_exp2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (rm_vld_reg[2]),
        .operand  (ex_operand),
        .side_in  ({rm_act_reg[2], rm_dom_reg[2], 1'b0}),
        .out_valid(ex_valid),
        .value    (ex_value),
        .ovf      (ex_ovf),
        .side_out (ex_side)
    );

    assign ex_act = ex_side[3:2];
    assign ex_dom = ex_side[1];

    // log2 value delayed to line up with the exp2 output
    logic [31:0] lgd_reg [6];
    always_ff @(posedge clk) begin
        lgd_reg[0] <= rm_lg_reg[1];
        for (int i = 1; i < 6; i++) begin
            lgd_reg[i] <= lgd_reg[i-1];
        end
    end

    always_comb begin
        res.result = '0;
        res.status = ST_OK;
        unique case (action_t'(ex_act))
            ACT_LOG2:
            begin
                res.result = lgd_reg[5];
                res.status = ex_dom ? ST_DOMAIN : ST_OK;
            end
            ACT_EXP2:
            begin
                res.result = ex_value;
                res.status = ex_ovf ? ST_OVF : ST_OK;
            end
            ACT_POW:
            begin
                res.result = ex_value;
                res.status = ex_dom ? ST_DOMAIN : (ex_ovf ? ST_OVF : ST_OK);
            end
            default:
            begin
                res.result = '0;
                res.status = ST_OK;
            end
        endcase
    end

    // credit count: items in pipe plus queued results
    assign push = ex_valid;
    assign pop  = out_valid && !out_stall;

    always_comb begin
        cnt_next = cnt_reg;
        if ((in_valid && !in_stall) && !pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (!(in_valid && !in_stall) && pop) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    // never let more items be outstanding than the queue holds
    assign in_stall = (cnt_reg >= CntW'(QDepth));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
            qn_reg  <= '0;
        end
        else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wp_reg <= wp_reg + 4'd1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 4'd1;
            end
            qn_reg <= qn_reg + CntW'(push) - CntW'(pop);
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            q_reg[wp_reg] <= res;
        end
    end

    assign out_valid = (qn_reg != '0);
    assign out_data  = q_reg[rp_reg];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(QDepth))
        else $error("in-flight count exceeds queue depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (qn_reg != CntW'(QDepth) || pop))
        else $error("result queue overflow");
    a_q_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        qn_reg <= cnt_reg)
        else $error("queue holds more than credited");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status != ST_RSVD))
        else $error("reserved status code");

endmodule
